[design/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants of the block buffer cache
// slot count, field widths, request and status codes, cell control struct
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int NumBuffers = 32;
  localparam int SlotW      = $clog2(NumBuffers);
  localparam int DevW       = 8;
  localparam int BlockW     = 24;
  localparam int RefW       = 8;
  localparam int OutSlotW   = 5;

  typedef enum logic [1:0] {
    MODE_GET     = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_PIN     = 2'd2,
    MODE_UNPIN   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_SEARCH = 2'd1,
    FSM_UPDATE = 2'd2,
    FSM_OUT    = 2'd3
  } fsm_e;

  typedef struct packed {
    logic [DevW-1:0]   dev;
    logic [BlockW-1:0] block;
  } tag_t;

  typedef struct packed {
    logic [OutSlotW-1:0] out_slot;
    logic                hit;
    logic                needs_read;
    logic [1:0]          status;
    logic [RefW-1:0]     ref_count;
  } result_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             search;   // compare the tag of the request
    logic             write;    // apply the chosen update
    logic [SlotW-1:0] sel;      // slot that is updated
    logic             retag;    // load new tag
    logic             set_valid;
    logic             inc;
    logic             dec;
    logic             load_one;
    logic             newest;   // move sel to most recent
    logic [SlotW-1:0] old_rank; // rank of sel before the move
    tag_t             tag;
  } cell_ctl_t;

  // candidate passed from one cell to the next along the chain
  typedef struct packed {
    logic             hit_found;
    logic [SlotW-1:0] hit_slot;
    logic [SlotW-1:0] hit_rank;
    logic [RefW-1:0]  hit_refs;
    logic             hit_valid;
    logic             free_found;
    logic [SlotW-1:0] free_slot;
    logic [SlotW-1:0] free_rank;
  } chain_t;

endpackage

[design/lbc_if.sv]
// ----------------------------------------------------------------------------
// lbc_req_if / lbc_rsp_if: valid-ready channels of the buffer cache
// request carries mode and tag or slot, response carries one result
// ----------------------------------------------------------------------------
interface lbc_req_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [lbc_pkg::DevW-1:0]   dev;
  logic [lbc_pkg::BlockW-1:0] block;
  logic [4:0]            slot;
  modport source (output valid, mode, dev, block, slot, input ready);
  modport sink   (input valid, mode, dev, block, slot, output ready);
endinterface

interface lbc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [lbc_pkg::OutSlotW-1:0] out_slot;
  logic                      hit;
  logic                      needs_read;
  logic [1:0]                status;
  logic [lbc_pkg::RefW-1:0]  ref_count;
  modport source (output valid, out_slot, hit, needs_read, status, ref_count,
                  input ready);
  modport sink   (input valid, out_slot, hit, needs_read, status, ref_count,
                  output ready);
endinterface

[design/lru_block_buffer_cache_unit.sv]
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit: LRU block buffer cache with reference counts
//
//   channel | dir | handshake    | payload
//   req     | in  | valid/ready  | mode, dev, block, slot
//   rsp     | out | valid/ready  | out_slot, hit, needs_read, status, ref_count
//
// A get walks the tag search down the cell chain, one cell per cycle,
// then passes the update and output states before the response
// transaction; release, pin and unpin do not walk the chain.
// The next request is accepted in the cycle after the response transaction.
// Reset restores slot ranks to their index and clears all tags and counts.
// One request is in flight at a time; a stalled response holds in its
// register and the request side waits until it is taken.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbc_req_if.sink    req,
  lbc_rsp_if.source  rsp
);
  import lbc_pkg::*;

  localparam int CntW = $clog2(NumBuffers + 1);

  fsm_e              state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        mode_q;
  tag_t              tag_q;
  logic [4:0]        slot_q;
  result_t           res_q, res_d;
  cell_ctl_t         ctl;
  chain_t            chain [NumBuffers+1];
  logic [RefW-1:0]   refs  [NumBuffers];
  logic [SlotW-1:0]  rank  [NumBuffers];
  logic              upd_q, upd_d;
  cell_ctl_t         wctl_q, wctl_d;
  logic              slot_ok;
  logic [SlotW-1:0]  sidx;
  chain_t            fin;

  assign chain[0] = '0;
  assign slot_ok  = ({27'd0, slot_q} < 32'(NumBuffers));
  assign sidx     = SlotW'(slot_q);
  assign fin      = chain[NumBuffers];

  // cell row
  for (genvar g = 0; g < NumBuffers; g++) begin : g_cell
    lbc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (SlotW'(g)),
      .ctl_i   (ctl),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .refs_o  (refs[g]),
      .rank_o  (rank[g])
    );
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      mode_q <= req.mode;
      tag_q  <= '{dev: req.dev, block: req.block};
      slot_q <= req.slot;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      cnt_q   <= '0;
      upd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      upd_q   <= upd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    wctl_q <= wctl_d;
  end

  // next state, decision and cell control
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    wctl_d    = wctl_q;
    upd_d     = 1'b0;
    req.ready = (state_q == FSM_IDLE);
    rsp.valid = (state_q == FSM_OUT);
    ctl       = wctl_q;
    ctl.write = upd_q;
    ctl.tag   = upd_q ? wctl_q.tag : tag_q;
    ctl.search = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        if (req.valid) begin
          state_d = FSM_SEARCH;
          cnt_d   = '0;
        end
      end
      FSM_SEARCH: begin
        if (mode_q == MODE_GET) begin
          ctl.search = 1'b1;
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q == CntW'(NumBuffers)) begin
            state_d = FSM_UPDATE;
          end
        end else begin
          state_d = FSM_UPDATE;
        end
      end
      FSM_UPDATE: begin
        wctl_d     = '0;
        wctl_d.tag = tag_q;
        res_d      = '0;
        if (mode_q == MODE_GET) begin
          if (fin.hit_found) begin
            res_d.out_slot = OutSlotW'(fin.hit_slot);
            res_d.hit      = 1'b1;
            if (fin.hit_refs == '1) begin
              res_d.status    = ST_OVER;
              res_d.ref_count = '1;
            end else begin
              res_d.needs_read = !fin.hit_valid;
              res_d.ref_count  = fin.hit_refs + RefW'(1);
              wctl_d.sel       = fin.hit_slot;
              wctl_d.inc       = 1'b1;
              wctl_d.set_valid = 1'b1;
              upd_d            = 1'b1;
            end
          end else if (fin.free_found) begin
            res_d.out_slot   = OutSlotW'(fin.free_slot);
            res_d.needs_read = 1'b1;
            res_d.ref_count  = RefW'(1);
            wctl_d.sel       = fin.free_slot;
            wctl_d.retag     = 1'b1;
            wctl_d.load_one  = 1'b1;
            wctl_d.set_valid = 1'b1;
            upd_d            = 1'b1;
          end else begin
            res_d.status = ST_NOFREE;
          end
        end else begin
          res_d.out_slot = slot_q;
          if (!slot_ok) begin
            res_d.status = ST_NOFREE;
          end else if (mode_q == MODE_PIN) begin
            if (refs[sidx] == '1) begin
              res_d.status    = ST_OVER;
              res_d.ref_count = '1;
            end else begin
              res_d.ref_count = refs[sidx] + RefW'(1);
              wctl_d.sel      = sidx;
              wctl_d.inc      = 1'b1;
              upd_d           = 1'b1;
            end
          end else begin
            if (refs[sidx] == '0) begin
              res_d.status = ST_UNDER;
            end else begin
              res_d.ref_count = refs[sidx] - RefW'(1);
              wctl_d.sel      = sidx;
              wctl_d.dec      = 1'b1;
              wctl_d.old_rank = rank[sidx];
              wctl_d.newest   = (mode_q == MODE_RELEASE) && (refs[sidx] == RefW'(1));
              upd_d           = 1'b1;
            end
          end
        end
        state_d = FSM_OUT;
      end
      FSM_OUT: begin
        if (rsp.ready) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  assign rsp.out_slot   = res_q.out_slot;
  assign rsp.hit        = res_q.hit;
  assign rsp.needs_read = res_q.needs_read;
  assign rsp.status     = res_q.status;
  assign rsp.ref_count  = res_q.ref_count;

  // checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.ready && rsp.valid))
    else $error("request taken while response pending");
  a_upd_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_q |-> state_q == FSM_OUT)
    else $error("cell write outside update");
  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status == ST_UNDER |-> rsp.ref_count == '0)
    else $error("underflow with nonzero count");
  a_miss_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.hit && rsp.needs_read |-> rsp.ref_count == RefW'(1))
    else $error("miss fill without single reference");
endmodule

[design/lbc_cell.sv]
// ----------------------------------------------------------------------------
// lbc_cell: one buffer slot of the chain
// holds tag, valid, count and rank; merges its own candidates into the
// hit and free candidates handed on from the previous cell
// ----------------------------------------------------------------------------
module lbc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lbc_pkg::SlotW-1:0]     idx_i,
  input  lbc_pkg::cell_ctl_t            ctl_i,
  input  lbc_pkg::chain_t               chain_i,
  output lbc_pkg::chain_t               chain_o,
  output logic [lbc_pkg::RefW-1:0]      refs_o,
  output logic [lbc_pkg::SlotW-1:0]     rank_o
);
  import lbc_pkg::*;

  tag_t             tag_q;
  logic             valid_q;
  logic [RefW-1:0]  refs_q;
  logic [SlotW-1:0] rank_q;
  logic             me;
  logic             match;
  chain_t           ch_d, ch_q;

  assign me    = (ctl_i.sel == idx_i);
  assign match = (tag_q == ctl_i.tag);

  // candidate merge: most recent match, least recent free slot
  always_comb begin
    ch_d = chain_i;
    if (match && (!chain_i.hit_found || rank_q > chain_i.hit_rank)) begin
      ch_d.hit_found = 1'b1;
      ch_d.hit_slot  = idx_i;
      ch_d.hit_rank  = rank_q;
      ch_d.hit_refs  = refs_q;
      ch_d.hit_valid = valid_q;
    end
    if (refs_q == '0 && (!chain_i.free_found || rank_q < chain_i.free_rank)) begin
      ch_d.free_found = 1'b1;
      ch_d.free_slot  = idx_i;
      ch_d.free_rank  = rank_q;
    end
  end

  // candidate register toward the neighbor
  always_ff @(posedge clk_i) begin
    if (ctl_i.search) begin
      ch_q <= ch_d;
    end
  end

  // slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      valid_q <= 1'b0;
      refs_q  <= '0;
      rank_q  <= idx_i;
    end else if (ctl_i.write) begin
      if (me) begin
        if (ctl_i.retag)     tag_q   <= ctl_i.tag;
        if (ctl_i.set_valid) valid_q <= 1'b1;
        if (ctl_i.load_one)  refs_q  <= RefW'(1);
        else if (ctl_i.inc)  refs_q  <= refs_q + RefW'(1);
        else if (ctl_i.dec)  refs_q  <= refs_q - RefW'(1);
        if (ctl_i.newest)    rank_q  <= SlotW'(NumBuffers - 1);
      end else if (ctl_i.newest && rank_q > ctl_i.old_rank) begin
        rank_q <= rank_q - SlotW'(1);
      end
    end
  end

  assign chain_o = ch_q;
  assign refs_o  = refs_q;
  assign rank_o  = rank_q;
endmodule

[tb/sv/tb_if.sv]
// ----------------------------------------------------------------------------
// tb_if: note on channel interfaces
// the request and response interfaces come from the design folder; this file
// holds the transaction struct that the stimulus tasks of tb share
// ----------------------------------------------------------------------------
package tb_lbc_pkg;
  import lbc_pkg::*;

  // one request transaction
  typedef struct packed {
    mode_e             mode;
    logic [DevW-1:0]   dev;
    logic [BlockW-1:0] block;
    logic [4:0]        slot;
  } lbc_req_t;
endpackage

[tb/sv/lbc_checker.sv]
// ----------------------------------------------------------------------------
// lbc_checker: scoreboard of the block buffer cache
// mirrors tags, counts and lru ranks, predicts one response per request
// transaction and compares it field by field in order
// ----------------------------------------------------------------------------
module lbc_checker
  import lbc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  lbc_req_if     req,
  lbc_rsp_if     rsp,
  output int     errors_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DevW-1:0]   tag_dev   [NumBuffers];
  logic [BlockW-1:0] tag_block [NumBuffers];
  logic              slot_valid[NumBuffers];
  logic [RefW-1:0]   slot_refs [NumBuffers];
  int                lru_rank  [NumBuffers];
  result_t           want_q[$];

  assign pending_o = want_q.size();

  // report one mismatch and count it
  task automatic report(input string what, input int got, input int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    errors_o++;
  endtask

  // move a slot to most recent
  function automatic void promote(input int s);
    int old;
    old = lru_rank[s];
    for (int i = 0; i < NumBuffers; i++)
      if (lru_rank[i] > old) lru_rank[i]--;
    lru_rank[s] = NumBuffers - 1;
  endfunction

  // compute the response of one request and update the mirror
  function automatic result_t cache_access(input mode_e mode, input logic [DevW-1:0] dev,
                                           input logic [BlockW-1:0] blk,
                                           input logic [4:0] s);
    result_t r;
    int best;
    bit found;
    r = '0;
    r.out_slot = s;
    best = 0;
    found = 0;
    if (mode == MODE_GET) begin
      r.out_slot = '0;
      for (int i = 0; i < NumBuffers; i++)
        if (tag_dev[i] == dev && tag_block[i] == blk &&
            (!found || lru_rank[i] > lru_rank[best])) begin
          best = i;
          found = 1;
        end
      if (found) begin
        r.out_slot = OutSlotW'(best);
        r.hit = 1'b1;
        if (slot_refs[best] == 8'hff) begin
          r.status = ST_OVER;
          r.ref_count = 8'hff;
        end else begin
          slot_refs[best]++;
          r.needs_read = !slot_valid[best];
          slot_valid[best] = 1'b1;
          r.status = ST_OK;
          r.ref_count = slot_refs[best];
        end
        return r;
      end
      for (int i = 0; i < NumBuffers; i++)
        if (slot_refs[i] == 0 && (!found || lru_rank[i] < lru_rank[best])) begin
          best = i;
          found = 1;
        end
      if (!found) begin
        r.status = ST_NOFREE;
        return r;
      end
      tag_dev[best] = dev;
      tag_block[best] = blk;
      slot_refs[best] = RefW'(1);
      slot_valid[best] = 1'b1;
      r.out_slot = OutSlotW'(best);
      r.needs_read = 1'b1;
      r.status = ST_OK;
      r.ref_count = RefW'(1);
      return r;
    end
    if (s >= NumBuffers) begin
      r.status = ST_NOFREE;
      return r;
    end
    if (mode == MODE_PIN) begin
      if (slot_refs[s] == 8'hff) begin
        r.status = ST_OVER;
        r.ref_count = 8'hff;
      end else begin
        slot_refs[s]++;
        r.status = ST_OK;
        r.ref_count = slot_refs[s];
      end
      return r;
    end
    // release or unpin
    if (slot_refs[s] == 0) begin
      r.status = ST_UNDER;
      return r;
    end
    slot_refs[s]--;
    if (mode == MODE_RELEASE && slot_refs[s] == 0) promote(s);
    r.status = ST_OK;
    r.ref_count = slot_refs[s];
    return r;
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, exp;
    if (!rst_ni) begin
      for (int i = 0; i < NumBuffers; i++) begin
        tag_dev[i] = '0;
        tag_block[i] = '0;
        slot_valid[i] = 1'b0;
        slot_refs[i] = '0;
        lru_rank[i] = i;
      end
      want_q.delete();
      errors_o = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.out_slot, rsp.hit, rsp.needs_read, rsp.status, rsp.ref_count};
        if (want_q.size() == 0) begin
          report("unexpected response", got.out_slot, -1);
        end else begin
          exp = want_q.pop_front();
          if (got.out_slot != exp.out_slot) report("out_slot", got.out_slot, exp.out_slot);
          if (got.hit != exp.hit) report("hit", got.hit, exp.hit);
          if (got.needs_read != exp.needs_read)
            report("needs_read", got.needs_read, exp.needs_read);
          if (got.status != exp.status) report("status", got.status, exp.status);
          if (got.ref_count != exp.ref_count)
            report("ref_count", got.ref_count, exp.ref_count);
        end
      end
      if (req.valid && req.ready)
        want_q.push_back(cache_access(mode_e'(req.mode), req.dev, req.block, req.slot));
    end
  end
endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression of the lru block buffer cache
// directed corner transactions, then random get/release/pin/unpin traffic on
// a small tag set under three stall profiles and a long response hold-off
// ----------------------------------------------------------------------------
module tb;
  import lbc_pkg::*;
  import tb_lbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   src_idle_pct;
  int   snk_idle_pct;
  bit   hold_off;

  lbc_req_if req ();
  lbc_rsp_if rsp ();

  lru_block_buffer_cache_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  lbc_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req),
    .rsp       (rsp),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // response ready with random stalls and an optional hold-off
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // send one request transaction, idling at random beforehand;
  // valid stays up after acceptance until the next call decides
  task automatic send(input lbc_req_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.mode  <= t.mode;
    req.dev   <= t.dev;
    req.block <= t.block;
    req.slot  <= t.slot;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random transaction on a narrow tag space so hits and evictions recur
  function automatic lbc_req_t rand_req();
    lbc_req_t t;
    int pick;
    pick = $urandom_range(99);
    t.mode  = pick < 45 ? MODE_GET : pick < 75 ? MODE_RELEASE :
              pick < 88 ? MODE_PIN : MODE_UNPIN;
    t.dev   = $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(3));
    t.block = $urandom_range(9) == 0 ? 24'($urandom) : 24'($urandom_range(40));
    t.slot  = 5'($urandom);
    return t;
  endfunction

  initial begin
    lbc_req_t t;
    int waited;
    req.valid = 1'b0;
    req.mode  = MODE_GET;
    req.dev   = '0;
    req.block = '0;
    req.slot  = '0;
    hold_off  = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset tag hit, extremes, underflow, overflow, full pool
    send('{MODE_GET, 8'h00, 24'h000000, 5'd0});
    send('{MODE_GET, 8'hff, 24'hffffff, 5'd31});
    send('{MODE_GET, 8'hff, 24'hffffff, 5'd0});
    send('{MODE_RELEASE, 8'h00, 24'h0, 5'd31});
    send('{MODE_UNPIN, 8'h00, 24'h0, 5'd5});
    send('{MODE_RELEASE, 8'h00, 24'h0, 5'd5});
    send('{MODE_PIN, 8'h00, 24'h0, 5'd31});
    send('{MODE_UNPIN, 8'h00, 24'h0, 5'd31});
    send('{MODE_GET, 8'haa, 24'h555555, 5'd0});
    send('{MODE_GET, 8'h55, 24'haaaaaa, 5'd0});
    // pin slot 31 up to saturation, then overflow on pin and on get hit
    for (int i = 0; i < 256; i++) send('{MODE_PIN, 8'h0, 24'h0, 5'd31});
    send('{MODE_GET, 8'h00, 24'h000000, 5'd0});
    // fill the pool with distinct tags to reach the no-free case
    for (int i = 0; i < 33; i++) send('{MODE_GET, 8'h7, 24'(1000 + i), 5'd0});
    for (int i = 0; i < 32; i++) send('{MODE_RELEASE, 8'h0, 24'h0, 5'(i)});

    // random phases under three stall profiles
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = ph == 0 ? 36 : ph == 1 ? 71 : 0;
      snk_idle_pct = ph == 0 ? 71 : ph == 1 ? 36 : 0;
      for (int n = 0; n < 106; n++) begin
        if (ph == 2 && n == 50) begin
          // hold the response side off while requests keep coming
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(negedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        send(rand_req());
      end
    end
    req.valid <= 1'b0;

    // drain, then settle
    waited = 0;
    while ((pending != 0 || hold_off) && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
